// ===== rtl/spsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spsc_pkg;

	// number of boards on the chain
	localparam int BOARDS = 4;
	localparam int BOARD_W = (BOARDS > 1) ? $clog2(BOARDS) : 1;

	localparam int MOTORS = 4;

	// coil patterns after reset: 0110, 0011, 1001, 1100
	localparam logic [15:0] PATTERNS_RESET = 16'hC936;

	// command codes
	typedef enum logic [2:0] {
		CMD_STEP   = 3'd0,
		CMD_PAUSE  = 3'd1,
		CMD_BUTTON = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_WRITE  = 3'd4
	} cmd_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_WR_READ,
		ST_WR_EMIT
	} state_t;

	// per motor state
	typedef struct packed {
		logic       paused;
		logic [1:0] phase;
	} motor_t;

	// one memory word per board
	typedef struct packed {
		logic [7:0]          button;
		motor_t [MOTORS-1:0] motor;
	} board_word_t;

	localparam board_word_t WORD_RESET = '{
		button: 8'h00,
		motor:  {MOTORS{3'b100}}
	};

	// coil nibble of one motor, zero while paused
	function automatic logic [3:0] motor_nibble(input motor_t m, input logic [15:0] pat);
		logic [3:0] nib;
		begin
			case (m.phase)
				2'd0: nib = pat[3:0];
				2'd1: nib = pat[7:4];
				2'd2: nib = pat[11:8];
				2'd3: nib = pat[15:12];
				default: nib = 4'h0;
			endcase
			motor_nibble = m.paused ? 4'h0 : nib;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/stepper_phase_shift_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-phase stepper driver for a chain of shift-register boards.
// Command channel (in_valid/in_ready): command, board, motor. Step, pause,
// set button and clear button read the board's word from the state memory
// and write it back in the next cycle; only then is a new command taken.
// Unknown commands and boards beyond the chain are taken and change nothing.
// A write command emits 3 bytes per board, last board first: button byte,
// motor byte 1, motor byte 0, with last_byte on the final one. Each board's
// word is first read from the state memory, then its three bytes are emitted.
// Result channel (out_valid/out_ready) has one output register; a stall of
// the receiver holds the byte and pauses the walk over the boards. The next
// command is taken as soon as the last byte sits in the output register.
// Config channel (cfg_valid/cfg_ready) writes the packed coil patterns; it
// is always ready and should only be used while the block is idle.
// After reset every motor is paused at phase 0 and all button bytes are
// zero: per-board valid bits make unwritten memory words read as reset.
module stepper_phase_shift_chain (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [1:0] board,
	input  wire logic [1:0] motor,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_byte,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int BW = spsc_pkg::BOARD_W;

	spsc_pkg::state_t state_q, state_d;

	logic [15:0]             patterns_q;
	logic [spsc_pkg::BOARDS-1:0] valid_q;
	spsc_pkg::board_word_t   mem [spsc_pkg::BOARDS];
	spsc_pkg::board_word_t   rd_data_q;
	logic                    rd_vld_q;
	spsc_pkg::board_word_t   cur_word;
	spsc_pkg::board_word_t   new_word;

	logic [2:0]    cmd_q;
	logic [BW-1:0] addr_q;
	logic [1:0]    motor_q;
	logic [BW-1:0] k_q;
	logic [1:0]    j_q;

	logic          accept;
	logic          board_ok;
	logic          motor_cmd;
	logic          mem_re;
	logic          mem_we;
	logic [BW-1:0] raddr;
	logic          slot_free;
	logic          emit;
	logic          last_sel;
	logic [7:0]    byte_sel;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_byte_q;

	// command decode
	assign accept    = in_valid && in_ready;
	assign board_ok  = 32'(board) < spsc_pkg::BOARDS;
	assign motor_cmd = board_ok && (command == spsc_pkg::CMD_STEP ||
		command == spsc_pkg::CMD_PAUSE || command == spsc_pkg::CMD_BUTTON ||
		command == spsc_pkg::CMD_CLEAR);
	assign slot_free = !out_valid_q || out_ready;
	assign last_sel  = (k_q == '0) && (j_q == 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spsc_pkg::ST_IDLE: begin
				if (accept && command == spsc_pkg::CMD_WRITE)
					state_d = spsc_pkg::ST_WR_READ;
				else if (accept && motor_cmd)
					state_d = spsc_pkg::ST_MODIFY;
			end
			spsc_pkg::ST_MODIFY:  state_d = spsc_pkg::ST_IDLE;
			spsc_pkg::ST_WR_READ: state_d = spsc_pkg::ST_WR_EMIT;
			spsc_pkg::ST_WR_EMIT: begin
				if (slot_free && j_q == 2'd2)
					state_d = (k_q == '0) ? spsc_pkg::ST_IDLE : spsc_pkg::ST_WR_READ;
			end
			default: state_d = spsc_pkg::ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		raddr    = k_q;
		emit     = 1'b0;
		case (state_q)
			spsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				mem_re   = in_valid && motor_cmd;
				raddr    = BW'(board);
			end
			spsc_pkg::ST_MODIFY:  mem_we = 1'b1;
			spsc_pkg::ST_WR_READ: mem_re = 1'b1;
			spsc_pkg::ST_WR_EMIT: emit   = slot_free;
			default: ;
		endcase
	end

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsc_pkg::ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept && command == spsc_pkg::CMD_WRITE) begin
				k_q <= BW'(spsc_pkg::BOARDS - 1);
				j_q <= '0;
			end else if (emit) begin
				if (j_q == 2'd2) begin
					j_q <= '0;
					k_q <= k_q - BW'(1);
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

	// held command for the write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			addr_q  <= BW'(board);
			motor_q <= motor;
		end
	end

	// coil pattern register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			patterns_q <= spsc_pkg::PATTERNS_RESET;
		else if (cfg_valid && cfg_ready)
			patterns_q <= cfg_data;
	end

	// board state memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr_q] <= new_word;
		if (mem_re)
			rd_data_q <= mem[raddr];
	end

	// per board valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				valid_q[addr_q] <= 1'b1;
			if (mem_re)
				rd_vld_q <= valid_q[raddr];
		end
	end

	// read-modify of the board word
	assign cur_word = rd_vld_q ? rd_data_q : spsc_pkg::WORD_RESET;

	always_comb begin
		new_word = cur_word;
		case (cmd_q)
			spsc_pkg::CMD_STEP: begin
				new_word.motor[motor_q].paused = 1'b0;
				new_word.motor[motor_q].phase  = cur_word.motor[motor_q].phase + 2'd1;
			end
			spsc_pkg::CMD_PAUSE:  new_word.motor[motor_q].paused = 1'b1;
			spsc_pkg::CMD_BUTTON: new_word.button = 8'h80 >> motor_q;
			spsc_pkg::CMD_CLEAR:  new_word.button = 8'h00;
			default: ;
		endcase
	end

	// byte select for the chain
	always_comb begin
		case (j_q)
			2'd0: byte_sel = cur_word.button;
			2'd1: byte_sel = {spsc_pkg::motor_nibble(cur_word.motor[2], patterns_q),
				spsc_pkg::motor_nibble(cur_word.motor[3], patterns_q)};
			2'd2: byte_sel = {spsc_pkg::motor_nibble(cur_word.motor[0], patterns_q),
				spsc_pkg::motor_nibble(cur_word.motor[1], patterns_q)};
			default: byte_sel = 8'h00;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= byte_sel;
			last_byte_q <= last_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

endmodule

`default_nettype wire

// ===== sim/spsc_chain_checker.sv =====
`timescale 1ns / 1ps

// watches the command, config and byte channels of the stepper chain driver,
// keeps its own copy of the motor and button state and checks every byte
module spsc_chain_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [1:0]  board,
	input  wire logic [1:0]  motor,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  out_byte,
	input  wire logic        last_byte,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	output int               errors,
	output int               waiting
);

	localparam int SLOTS = spsc_pkg::BOARDS * spsc_pkg::MOTORS;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} chain_byte_t;

	// shadow of the block state
	logic [15:0] coil_pattern;
	logic [1:0]  phase_idx [SLOTS];
	logic        is_paused [SLOTS];
	logic [7:0]  button_sel [spsc_pkg::BOARDS];

	// bytes still owed by the chain, oldest first
	chain_byte_t chain_bytes_q [$];
	chain_byte_t want;

	// coil nibble of one motor slot, blank while paused
	function automatic logic [3:0] coil_nibble(input int slot);
		if (is_paused[slot])
			return 4'h0;
		return coil_pattern[phase_idx[slot] * 4 +: 4];
	endfunction

	// full chain image, last board first
	task automatic queue_chain_write();
		chain_byte_t cb;
		for (int b = spsc_pkg::BOARDS - 1; b >= 0; b--) begin
			cb.data = button_sel[b];
			cb.last = 1'b0;
			chain_bytes_q.push_back(cb);
			cb.data = {coil_nibble(b * spsc_pkg::MOTORS + 2),
				coil_nibble(b * spsc_pkg::MOTORS + 3)};
			chain_bytes_q.push_back(cb);
			cb.data = {coil_nibble(b * spsc_pkg::MOTORS),
				coil_nibble(b * spsc_pkg::MOTORS + 1)};
			cb.last = (b == 0);
			chain_bytes_q.push_back(cb);
		end
	endtask

	// state update for one accepted command item
	task automatic apply_command(input logic [2:0] code, input logic [1:0] b,
			input logic [1:0] m);
		int slot;
		slot = int'(b) * spsc_pkg::MOTORS + int'(m);
		if (code == spsc_pkg::CMD_WRITE) begin
			queue_chain_write();
			return;
		end
		// boards past the end of the chain are ignored
		if (int'(b) >= spsc_pkg::BOARDS)
			return;
		case (code)
			spsc_pkg::CMD_STEP: begin
				is_paused[slot] = 1'b0;
				phase_idx[slot] = phase_idx[slot] + 2'd1;
			end
			spsc_pkg::CMD_PAUSE:  is_paused[slot] = 1'b1;
			spsc_pkg::CMD_BUTTON: button_sel[b] = 8'h80 >> m;
			spsc_pkg::CMD_CLEAR:  button_sel[b] = 8'h00;
			default: ;
		endcase
	endtask

	// byte compare first, then config and command updates
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_pattern = spsc_pkg::PATTERNS_RESET;
			for (int s = 0; s < SLOTS; s++) begin
				phase_idx[s] = 2'd0;
				is_paused[s] = 1'b1;
			end
			for (int b = 0; b < spsc_pkg::BOARDS; b++)
				button_sel[b] = 8'h00;
			chain_bytes_q.delete();
			errors = 0;
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (chain_bytes_q.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual %02h last %0b",
						$time, out_byte, last_byte);
					errors++;
				end else begin
					want = chain_bytes_q.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.data, out_byte);
						errors++;
					end
					if (last_byte !== want.last) begin
						$display("%0t: last_byte expected %0b actual %0b",
							$time, want.last, last_byte);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				coil_pattern = cfg_data;
			if (in_valid && in_ready)
				apply_command(command, board, motor);
			waiting = chain_bytes_q.size();
		end
	end

endmodule

// ===== sim/tb_stepper_phase_shift_chain.sv =====
`timescale 1ns / 1ps

module tb_stepper_phase_shift_chain;

	// command codes the block ignores
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 50;
	localparam int SETTLE       = 20;
	localparam int TAIL         = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = spsc_pkg::CMD_STEP;
	logic [1:0]  board = 2'd0;
	logic [1:0]  motor = 2'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_byte;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	int chk_errors;
	int chk_waiting;

	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;

	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int holds_asked = 0;
	int holds_done = 0;
	int stall_left = 0;

	always #2 clk = ~clk;

	stepper_phase_shift_chain dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.board     (board),
		.motor     (motor),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	spsc_chain_checker chain_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.board     (board),
		.motor     (motor),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (chk_errors),
		.waiting   (chk_waiting)
	);

	// handshakes seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 11) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	// byte receiver with random stalls and requested long hold-offs
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done++;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (rx_gaps && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	// offer one command item and wait until it is taken
	task automatic send_item(input logic [2:0] code, input logic [1:0] b,
			input logic [1:0] m);
		command <= code;
		board <= b;
		motor <= m;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_taken);
	endtask

	task automatic sender_gap();
		int n;
		n = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop offering until every owed byte is out, then let the block settle
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		do @(negedge clk); while (chk_waiting != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_patterns(input logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// random commands, writes frequent enough to keep bytes flowing
	task automatic random_run(input int count, input bit pause_midway);
		int done;
		int roll;
		logic [2:0] code;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 35)
				code = spsc_pkg::CMD_STEP;
			else if (roll < 50)
				code = spsc_pkg::CMD_PAUSE;
			else if (roll < 62)
				code = spsc_pkg::CMD_BUTTON;
			else if (roll < 72)
				code = spsc_pkg::CMD_CLEAR;
			else if (roll < 94)
				code = spsc_pkg::CMD_WRITE;
			else
				code = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
			send_item(code, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			if (code <= spsc_pkg::CMD_WRITE)
				done++;
			// sender waits for the chain to empty when half the items are done
			if (pause_midway && done == count / 2)
				drain(0);
			else
				sender_gap();
		end
	endtask

	// overall run limit
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset image, steps with wraparound, buttons, pause, clear, ignored codes
		rx_gaps = 1'b1;
		send_item(spsc_pkg::CMD_WRITE, 2'd0, 2'd0);
		send_item(spsc_pkg::CMD_STEP, 2'd0, 2'd0);
		send_item(spsc_pkg::CMD_STEP, 2'd0, 2'd1);
		send_item(spsc_pkg::CMD_STEP, 2'd0, 2'd1);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd2);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_BUTTON, 2'd0, 2'd0);
		send_item(spsc_pkg::CMD_BUTTON, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_BUTTON, 2'd1, 2'd1);
		send_item(spsc_pkg::CMD_BUTTON, 2'd2, 2'd2);
		send_item(CMD_RSVD5, 2'd3, 2'd3);
		send_item(CMD_RSVD6, 2'd1, 2'd2);
		send_item(CMD_RSVD7, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_WRITE, 2'd2, 2'd1);
		send_item(spsc_pkg::CMD_PAUSE, 2'd0, 2'd0);
		send_item(spsc_pkg::CMD_CLEAR, 2'd1, 2'd0);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_STEP, 2'd3, 2'd3);
		send_item(spsc_pkg::CMD_WRITE, 2'd3, 2'd3);
		drain(SETTLE);

		// all-zero patterns, no idling on either side
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_patterns(16'h0000);
		random_run(PHASE_ITEMS, 1'b0);
		drain(SETTLE);

		// all-ones patterns, long receiver hold-off while commands keep coming
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		write_patterns(16'hFFFF);
		holds_asked++;
		random_run(PHASE_ITEMS, 1'b0);
		drain(SETTLE);

		// random patterns, sender pauses halfway for the chain to empty
		write_patterns(16'($urandom_range(0, 16'hFFFF)));
		random_run(PHASE_ITEMS, 1'b1);
		drain(SETTLE);

		write_patterns(16'($urandom_range(0, 16'hFFFF)));
		random_run(PHASE_ITEMS, 1'b0);
		drain(TAIL);

		if (chk_errors == 0 && chk_waiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== stepper_phase_shift_chain.f =====
rtl/spsc_pkg.sv
rtl/stepper_phase_shift_chain.sv
sim/spsc_chain_checker.sv
sim/tb_stepper_phase_shift_chain.sv
